@@ rtl/fwm_pkg.sv @@
// Shared constants of the frame rate window meter.
package fwm_pkg;
    localparam int unsigned RING_DEPTH_DEF  = 1024;
    localparam logic [31:0] REFRESH_RST     = 32'd250000;
    localparam logic [31:0] WINDOW_RST      = 32'd1000000;
    localparam logic [27:0] RATE_SCALE      = 28'd256000000;
    localparam logic [9:0]  MS_SCALE        = 10'd1000;
    localparam int unsigned NUM_W           = 56;
    localparam logic        REG_REFRESH     = 1'b0;
    localparam logic        REG_WINDOW      = 1'b1;
endpackage

@@ rtl/fwm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module fwm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and read; the read data is registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/frame_rate_window_meter_unit.sv @@
// Frame rate window meter: top level with ring memories and serial divider.
// Each beat is one finished frame; one result beat follows per frame. A frame
// without refresh appends its entry and goes to the result, after first dropping
// the oldest entry when the ring is full. A refresh adds an age check per entry
// dropped from the window plus the final one, each a memory read, then a compare,
// and two serial divisions of 56 steps each, one quotient bit a cycle; a zero or
// backward span skips the rate division. The next frame is taken as soon as the
// current result is loaded into the output register.
module frame_rate_window_meter_unit #(
    parameter int unsigned RING_DEPTH = fwm_pkg::RING_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_frame_begin_us,
    input  logic [63:0] i_frame_end_us,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_refreshed,
    output logic [10:0] o_frames_in_window,
    output logic [31:0] o_rate_fps_q8,
    output logic [31:0] o_mean_frame_ms_q8,
    output logic        o_ring_overflow
);
    import fwm_pkg::*;

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned CW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(RING_DEPTH);
    localparam logic [5:0]    DIV_LAST = 6'(NUM_W - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DROP_RD, S_DROP, S_WRITE, S_EV_RD, S_EV_CHK,
        S_RATE, S_MEAN_LD, S_DIV, S_DONE
    } t_state;

    t_state        r_state;
    logic [31:0]   r_period, r_window;
    logic [63:0]   r_end;
    logic [31:0]   r_len;
    logic [AW-1:0] r_ptr;
    logic [CW-1:0] r_count;
    logic [47:0]   r_sum;
    logic [63:0]   r_last;
    logic [31:0]   r_rate, r_mean;
    logic          r_ovf, r_refr;
    logic [63:0]   r_oldest;
    logic [64:0]   r_rem;
    logic [NUM_W-1:0] r_num, r_quo;
    logic [63:0]   r_den;
    logic [5:0]    r_step;
    logic          r_div_mean;

    logic [63:0] end_rdata;
    logic [31:0] len_rdata;
    logic        ram_we;
    logic [AW:0] slot_sum;
    logic [AW-1:0] slot;
    logic [AW-1:0] n_ptr;
    logic [64:0] rem_sh;
    logic        rem_ge;
    logic [31:0] quo_sat;
    logic        refresh_due, is_old;

    // append slot: oldest plus count, wrapped
    assign slot_sum = {1'b0, r_ptr} + (AW+1)'(r_count);
    assign slot = (slot_sum >= (AW+1)'(RING_DEPTH)) ?
                  AW'(slot_sum - (AW+1)'(RING_DEPTH)) : slot_sum[AW-1:0];
    assign n_ptr = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
    assign ram_we = (r_state == S_WRITE);

    fwm_ram #(.WIDTH(64), .DEPTH(RING_DEPTH)) u_end_ring (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(slot), .i_wdata(r_end),
        .i_raddr(r_ptr), .o_rdata(end_rdata)
    );
    fwm_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_len_ring (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(slot), .i_wdata(r_len),
        .i_raddr(r_ptr), .o_rdata(len_rdata)
    );

    // full-precision compares for refresh and window age
    assign refresh_due = ({1'b0, r_last} + {33'b0, r_period}) < {1'b0, r_end};
    assign is_old      = ({1'b0, end_rdata} + {33'b0, r_window}) < {1'b0, r_end};

    // one restoring division step
    assign rem_sh  = {r_rem[63:0], r_num[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_den};
    assign quo_sat = (|r_quo[NUM_W-1:32]) ? 32'hFFFF_FFFF : r_quo[31:0];

    assign o_in_ready = (r_state == S_IDLE);

    // sequencer, state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= REFRESH_RST;
            r_window    <= WINDOW_RST;
            r_ptr       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_rate      <= '0;
            r_mean      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_REFRESH) r_period <= i_cfg_data;
                else                            r_window <= i_cfg_data;
            end
            // drop a taken result beat; the done state reloads it itself
            if (o_out_valid && i_out_ready && r_state != S_DONE) o_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_end  <= i_frame_end_us;
                        r_ovf  <= 1'b0;
                        r_refr <= 1'b0;
                        if (i_frame_end_us > i_frame_begin_us) begin
                            r_len <= (|((i_frame_end_us - i_frame_begin_us) >> 32)) ?
                                     32'hFFFF_FFFF : 32'(i_frame_end_us - i_frame_begin_us);
                        end else begin
                            r_len <= '0;
                        end
                        r_state <= (r_count >= CNT_FULL) ? S_DROP_RD : S_WRITE;
                    end
                end
                S_DROP_RD: r_state <= S_DROP;
                // drop the oldest entry of a full ring
                S_DROP: begin
                    r_sum   <= r_sum - 48'(len_rdata);
                    r_ptr   <= n_ptr;
                    r_count <= r_count - 1'b1;
                    r_ovf   <= 1'b1;
                    r_state <= S_WRITE;
                end
                // append the new frame
                S_WRITE: begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= r_sum + 48'(r_len);
                    r_state <= refresh_due ? S_EV_RD : S_DONE;
                end
                S_EV_RD: r_state <= S_EV_CHK;
                // evict entries older than the window
                S_EV_CHK: begin
                    if (r_count > CW'(1) && is_old) begin
                        r_sum   <= r_sum - 48'(len_rdata);
                        r_ptr   <= n_ptr;
                        r_count <= r_count - 1'b1;
                        r_state <= S_EV_RD;
                    end else begin
                        r_oldest <= end_rdata;
                        r_state  <= S_RATE;
                    end
                end
                // set up the rate division
                S_RATE: begin
                    r_refr <= 1'b1;
                    r_last <= r_end;
                    if (r_oldest >= r_end) begin
                        // zero or backward span: saturate the rate
                        r_quo   <= '1;
                        r_state <= S_MEAN_LD;
                    end else begin
                        r_num      <= NUM_W'(r_count * RATE_SCALE);
                        r_den      <= r_end - r_oldest;
                        r_rem      <= '0;
                        r_quo      <= '0;
                        r_step     <= '0;
                        r_div_mean <= 1'b0;
                        r_state    <= S_DIV;
                    end
                end
                // hold the rate, set up the mean division
                S_MEAN_LD: begin
                    r_rate     <= quo_sat;
                    r_num      <= {r_sum, 8'h00};
                    r_den      <= 64'(r_count * MS_SCALE);
                    r_rem      <= '0;
                    r_quo      <= '0;
                    r_step     <= '0;
                    r_div_mean <= 1'b1;
                    r_state    <= S_DIV;
                end
                // one quotient bit a cycle
                S_DIV: begin
                    r_num <= r_num << 1;
                    r_rem <= rem_ge ? rem_sh - {1'b0, r_den} : rem_sh;
                    r_quo <= {r_quo[NUM_W-2:0], rem_ge};
                    r_step <= r_step + 1'b1;
                    if (r_step == DIV_LAST) r_state <= r_div_mean ? S_DONE : S_MEAN_LD;
                end
                // hold the result until the output register is free
                S_DONE: begin
                    if (r_refr && r_div_mean) r_mean <= quo_sat;
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid        <= 1'b1;
                        o_refreshed        <= r_refr;
                        o_frames_in_window <= 11'(r_count);
                        o_ring_overflow    <= r_ovf;
                        o_rate_fps_q8      <= r_rate;
                        o_mean_frame_ms_q8 <= (r_refr && r_div_mean) ? quo_sat : r_mean;
                        r_div_mean         <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // the ring never holds more entries than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL) else $error("entry count beyond ring depth");
    // the oldest pointer stays inside the ring
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST) else $error("oldest pointer out of range");
    // a refreshed result always holds at least one frame
    a_refr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_refreshed) |-> (o_frames_in_window != 11'd0))
        else $error("refresh with empty window");
    // a new frame is taken only with the sequencer idle, which then leaves idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("sequencer did not start on accepted beat");
endmodule
